[hw/rtl/aeic_pkg.sv]
`default_nettype none

package aeic_pkg;

  localparam int MODE_W   = 2;
  localparam int NODE_W   = 8;
  localparam int STATUS_W = 2;

  // item modes
  localparam logic [MODE_W-1:0] MODE_FORCE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHECKED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CYCLE   = 2'd2;

  // what a word on the cell chain asks of each cell
  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_PROBE = 2'd1,
    KIND_SWEEP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic              edge_hit;
    logic              rev_hit;
    logic              fwd_hit;
  } ctl_t;

endpackage

`default_nettype wire

[hw/rtl/aeic_req_if.sv]
`default_nettype none

interface aeic_req_if;
  logic                          valid;
  logic                          ready;
  logic [aeic_pkg::MODE_W-1:0]   mode;
  logic [aeic_pkg::NODE_W-1:0]   source_node;
  logic [aeic_pkg::NODE_W-1:0]   dest_node;

  modport source (output valid, mode, source_node, dest_node, input ready);
  modport sink   (input valid, mode, source_node, dest_node, output ready);
endinterface

`default_nettype wire

[hw/rtl/aeic_rsp_if.sv]
`default_nettype none

interface aeic_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [aeic_pkg::STATUS_W-1:0] status;
  logic                          reachable;

  modport source (output valid, status, reachable, input ready);
  modport sink   (input valid, status, reachable, output ready);
endinterface

`default_nettype wire

[hw/rtl/acyclic_edge_insert_closure.sv]
// query, refused or present edge: the probe runs through all CELLS cells to the result;
// node out of range: result in the cycle after accept.
// insertion: a probe, then a sweep word down the chain and a row sweep
// through each cell's reach memory (CELLS = 2**CELL_BITS, one row per cycle).
// one word at a time; ready returns the cycle after the result is taken.
// reset: clearing sweep of every cell's memories, with ready low.
`default_nettype none

module acyclic_edge_insert_closure #(
  parameter int NODES     = 256,
  parameter int CELL_BITS = 2
) (
  input logic         clk,
  input logic         rst,
  aeic_req_if.sink    req,
  aeic_rsp_if.source  rsp
);

  localparam int CELLS      = 1 << CELL_BITS;
  localparam int IW         = $clog2(NODES);
  localparam int ROWS       = (NODES + CELLS - 1) / CELLS;
  localparam int CLEAR_WAIT = ROWS + 2;
  localparam int SWEEP_WAIT = CELLS + ROWS + 2;
  localparam int WW         = $clog2(SWEEP_WAIT + 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                         state;
  logic [WW-1:0]                  wait_cnt;
  logic [aeic_pkg::MODE_W-1:0]    mode_q;
  logic [aeic_pkg::STATUS_W-1:0]  status_q;
  logic                           reach_q;
  aeic_pkg::ctl_t                 inj_ctl;
  aeic_pkg::ctl_t                 inj_ctl_next;
  logic [NODES-1:0]               inj_row;

  aeic_pkg::ctl_t                 chain_ctl [CELLS+1];
  logic [NODES-1:0]               chain_row [CELLS+1];

  logic [aeic_pkg::MODE_W-1:0]    mode_eff;
  logic                           in_range;
  logic                           accept;
  logic                           probe_back;
  aeic_pkg::ctl_t                 ret;
  logic [IW-1:0]                  ret_d;
  logic [NODES-1:0]               to_set;
  logic                           do_insert;
  logic [aeic_pkg::STATUS_W-1:0]  probe_status;

  assign chain_ctl[0] = inj_ctl;
  assign chain_row[0] = inj_row;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    aeic_cell #(
      .NODES     (NODES),
      .CELL_BITS (CELL_BITS),
      .INDEX     (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (chain_ctl[k]),
      .row_in  (chain_row[k]),
      .ctl_out (chain_ctl[k+1]),
      .row_out (chain_row[k+1])
    );
  end

  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = (state == ST_DONE);
  assign rsp.status    = status_q;
  assign rsp.reachable = reach_q;

  assign mode_eff   = (req.mode == aeic_pkg::MODE_UNUSED) ? aeic_pkg::MODE_QUERY : req.mode;
  assign in_range   = (32'(req.source_node) < NODES) && (32'(req.dest_node) < NODES);
  assign accept     = req.valid && (state == ST_IDLE);
  assign ret        = chain_ctl[CELLS];
  assign ret_d      = IW'(ret.dst);
  assign probe_back = (state == ST_PROBE) && (ret.kind == aeic_pkg::KIND_PROBE);

  always_comb begin
    to_set        = chain_row[CELLS];
    to_set[ret_d] = 1'b1;
  end

  always_comb begin
    do_insert    = 1'b0;
    probe_status = aeic_pkg::STATUS_OK;
    unique case (mode_q)
      aeic_pkg::MODE_FORCE: begin
        do_insert = 1'b1;
      end
      aeic_pkg::MODE_CHECKED: begin
        if (ret.edge_hit) begin
          probe_status = aeic_pkg::STATUS_PRESENT;
        end else if (ret.src == ret.dst || ret.rev_hit) begin
          probe_status = aeic_pkg::STATUS_CYCLE;
        end else begin
          do_insert = 1'b1;
        end
      end
      default: begin
        probe_status = aeic_pkg::STATUS_OK;
      end
    endcase
  end

  // a probe or sweep word enters the chain for a single cycle
  always_comb begin
    inj_ctl_next      = inj_ctl;
    inj_ctl_next.kind = aeic_pkg::KIND_IDLE;
    if (accept && in_range) begin
      inj_ctl_next = '{kind: aeic_pkg::KIND_PROBE, src: req.source_node,
                       dst: req.dest_node, default: '0};
    end else if (probe_back && do_insert) begin
      inj_ctl_next = '{kind: aeic_pkg::KIND_SWEEP, src: ret.src,
                       dst: ret.dst, default: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      wait_cnt <= '0;
      inj_ctl  <= '{kind: aeic_pkg::KIND_IDLE, default: '0};
    end else begin
      inj_ctl <= inj_ctl_next;
      unique case (state)
        ST_CLEAR: begin
          if (wait_cnt == WW'(CLEAR_WAIT)) begin
            state <= ST_IDLE;
          end else begin
            wait_cnt <= wait_cnt + WW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_range) begin
              state <= ST_PROBE;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_PROBE: begin
          if (probe_back) begin
            if (do_insert) begin
              wait_cnt <= '0;
              state    <= ST_SWEEP;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SWEEP: begin
          if (wait_cnt == WW'(SWEEP_WAIT)) begin
            state <= ST_DONE;
          end else begin
            wait_cnt <= wait_cnt + WW'(1);
          end
        end
        ST_DONE: begin
          if (rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result word and chain row
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode_eff;
      inj_row  <= '0;
      status_q <= (mode_eff == aeic_pkg::MODE_QUERY) ? aeic_pkg::STATUS_OK
                                                      : aeic_pkg::STATUS_CYCLE;
      reach_q  <= 1'b0;
    end else if (probe_back) begin
      inj_row  <= to_set;
      status_q <= probe_status;
      // after an insertion the source always reaches the destination
      reach_q  <= do_insert | ret.fwd_hit;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/aeic_cell.sv]
`default_nettype none

module aeic_cell #(
  parameter int NODES     = 256,
  parameter int CELL_BITS = 2,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  aeic_pkg::ctl_t       ctl_in,
  input  logic [NODES-1:0]     row_in,
  output aeic_pkg::ctl_t       ctl_out,
  output logic [NODES-1:0]     row_out
);

  localparam int CELLS = 1 << CELL_BITS;
  localparam int IW    = $clog2(NODES);
  localparam int RW    = (IW > CELL_BITS) ? IW - CELL_BITS : 1;
  localparam int ROWS  = (NODES + CELLS - 1) / CELLS;
  localparam logic [RW-1:0] LAST = RW'(ROWS - 1);
  localparam logic [IW-1:0] SELF = IW'(INDEX);
  localparam logic [IW-1:0] MASK = IW'(CELLS - 1);

  // rows x with x % CELLS == INDEX live here, at local row x / CELLS
  logic [NODES-1:0] reach_mem [ROWS];
  logic [NODES-1:0] edge_mem  [ROWS];

  logic [IW-1:0]    in_s;
  logic [IW-1:0]    in_d;
  logic [IW-1:0]    q_s;
  logic [IW-1:0]    q_d;
  logic [RW-1:0]    rd_a_addr;
  logic [RW-1:0]    rd_b_addr;
  logic [RW-1:0]    rd_e_addr;
  logic [NODES-1:0] rd_a;
  logic [NODES-1:0] rd_b;
  logic [NODES-1:0] rd_e;

  logic             running;
  logic             clearing;
  logic [RW-1:0]    cnt;
  logic             wr_en;
  logic [RW-1:0]    wr_addr;
  logic [NODES-1:0] wr_reach;
  logic [NODES-1:0] wr_edge;
  logic [NODES-1:0] set_row;
  logic [IW-1:0]    sw_s;
  logic [IW-1:0]    sw_d;
  logic             is_s_row;

  aeic_pkg::ctl_t   ctl_q;
  logic [NODES-1:0] row_q;
  logic             own_s_q;
  logic             own_d_q;

  assign in_s = IW'(ctl_in.src);
  assign in_d = IW'(ctl_in.dst);
  assign q_s  = IW'(ctl_q.src);
  assign q_d  = IW'(ctl_q.dst);

  // the sweep owns port a and the edge port while it runs
  always_comb begin
    rd_b_addr = RW'(in_s >> CELL_BITS);
    if (running) begin
      rd_a_addr = cnt;
      rd_e_addr = cnt;
    end else begin
      rd_a_addr = RW'(in_d >> CELL_BITS);
      rd_e_addr = RW'(in_s >> CELL_BITS);
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= reach_mem[rd_a_addr];
    rd_b <= reach_mem[rd_b_addr];
    rd_e <= edge_mem[rd_e_addr];
    if (wr_en) begin
      reach_mem[wr_addr] <= wr_reach;
      edge_mem[wr_addr]  <= wr_edge;
    end
  end

  // sweep control; reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b1;
      clearing <= 1'b1;
      cnt      <= '0;
      wr_en    <= 1'b0;
      ctl_q    <= '{kind: aeic_pkg::KIND_IDLE, default: '0};
    end else begin
      ctl_q <= ctl_in;
      wr_en <= running;
      if (running) begin
        cnt <= cnt + RW'(1);
        if (cnt == LAST) begin
          running <= 1'b0;
        end
      end else if (ctl_in.kind == aeic_pkg::KIND_SWEEP) begin
        running  <= 1'b1;
        clearing <= 1'b0;
        cnt      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_q   <= row_in;
    wr_addr <= cnt;
    own_s_q <= (in_s & MASK) == SELF;
    own_d_q <= (in_d & MASK) == SELF;
    if (!running && ctl_in.kind == aeic_pkg::KIND_SWEEP) begin
      set_row <= row_in;
      sw_s    <= in_s;
      sw_d    <= in_d;
    end
  end

  assign is_s_row = ((sw_s & MASK) == SELF) && (wr_addr == RW'(sw_s >> CELL_BITS));

  // rows that reach the source, and the source row, take the destination set
  always_comb begin
    wr_reach = rd_a;
    wr_edge  = rd_e;
    if (clearing) begin
      wr_reach = '0;
      wr_edge  = '0;
    end else begin
      if (is_s_row || rd_a[sw_s]) begin
        wr_reach = rd_a | set_row;
      end
      if (is_s_row) begin
        wr_edge[sw_d] = 1'b1;
      end
    end
  end

  // a probe picks up what the owning cells hold
  always_comb begin
    ctl_out = ctl_q;
    row_out = row_q;
    if (ctl_q.kind == aeic_pkg::KIND_PROBE) begin
      if (own_d_q) begin
        row_out         = rd_a;
        ctl_out.rev_hit = rd_a[q_s];
      end
      if (own_s_q) begin
        ctl_out.fwd_hit  = rd_b[q_d];
        ctl_out.edge_hit = rd_e[q_d];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/aeic_check.sv]
`default_nettype none

module aeic_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [aeic_pkg::STATUS_W-1:0]  status,
  input logic                           reachable
);

  // result word held until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(reachable))
    else $error("result word dropped or changed while stalled");

  // one word in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second word accepted while one is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("ready while a result is pending");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status == aeic_pkg::STATUS_OK || status == aeic_pkg::STATUS_PRESENT ||
                  status == aeic_pkg::STATUS_CYCLE)
    else $error("undefined status code");

  // a present edge implies the source reaches the destination
  a_present_reach: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == aeic_pkg::STATUS_PRESENT |-> reachable)
    else $error("present edge reported unreachable");

endmodule

bind acyclic_edge_insert_closure aeic_check u_aeic_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .reachable (rsp.reachable)
);

`default_nettype wire
